>>> hw/rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// shared types and constants of the line and circle rasterizer
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int GridSize  = 256;
  localparam int CoordW    = $clog2(GridSize);
  localparam int AddrW     = 2 * CoordW;
  localparam int Depth     = GridSize * GridSize;
  localparam int InW       = 13;
  localparam int RadW      = 12;
  localparam int CodeW     = 4;
  localparam int WorkW     = 18;
  localparam int QDepth    = 2;

  localparam logic [CodeW-1:0] LineCode = 4'd10;

  typedef enum logic [1:0] {
    OP_CIRCLE = 2'd0,
    OP_LINE   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic signed [InW-1:0] ax;
    logic signed [InW-1:0] ay;
    logic signed [InW-1:0] bx;
    logic signed [InW-1:0] by;
    logic [RadW-1:0]       radius;
    logic [CodeW-1:0]      color;
  } cmd_t;

endpackage

>>> hw/rtl/lcr_front.sv
// ----------------------------------------------------------------------------
// lcr_front
// accepts items, orders line endpoints and queues commands for the back end
// ----------------------------------------------------------------------------
module lcr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic signed [lcr_pkg::InW-1:0] ax_i,
  input  logic signed [lcr_pkg::InW-1:0] ay_i,
  input  logic signed [lcr_pkg::InW-1:0] bx_i,
  input  logic signed [lcr_pkg::InW-1:0] by_i,
  input  logic [lcr_pkg::RadW-1:0]     radius_i,
  input  logic [lcr_pkg::CodeW-1:0]    color_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_take_i,
  output lcr_pkg::cmd_t                cmd_o
);

  localparam int InW_T = lcr_pkg::InW + 1;

  lcr_pkg::cmd_t q_mem [lcr_pkg::QDepth];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  lcr_pkg::cmd_t cls;
  logic          push, pop;

  // endpoint ordering: x ascending, steep or diagonal falling lines swapped back
  always_comb begin
    logic signed [InW_T-1:0] x1, y1, x2, y2, dx, dy;
    cls.op     = lcr_pkg::op_e'(op_i);
    cls.radius = radius_i;
    cls.color  = color_i;
    x1 = InW_T'(ax_i); y1 = InW_T'(ay_i); x2 = InW_T'(bx_i); y2 = InW_T'(by_i);
    if (bx_i < ax_i) begin
      x1 = InW_T'(bx_i); y1 = InW_T'(by_i); x2 = InW_T'(ax_i); y2 = InW_T'(ay_i);
    end
    dx = x2 - x1;
    dy = y2 - y1;
    if (dy < 0 && -dy >= dx) begin
      cls.ax = x2[lcr_pkg::InW-1:0]; cls.ay = y2[lcr_pkg::InW-1:0];
      cls.bx = x1[lcr_pkg::InW-1:0]; cls.by = y1[lcr_pkg::InW-1:0];
    end else begin
      cls.ax = x1[lcr_pkg::InW-1:0]; cls.ay = y1[lcr_pkg::InW-1:0];
      cls.bx = x2[lcr_pkg::InW-1:0]; cls.by = y2[lcr_pkg::InW-1:0];
    end
    if (op_i != lcr_pkg::OP_LINE) begin
      cls.ax = ax_i; cls.ay = ay_i; cls.bx = bx_i; cls.by = by_i;
    end
  end

  assign in_stall_o  = (cnt_q == 2'(lcr_pkg::QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(lcr_pkg::QDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule

>>> hw/rtl/lcr_back.sv
// ----------------------------------------------------------------------------
// lcr_back
// walks circles and lines one pixel per cycle, clears and reads the frame
// ----------------------------------------------------------------------------
module lcr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_take_o,
  input  lcr_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lcr_pkg::CodeW-1:0]     pixel_code_o
);

  localparam int W  = lcr_pkg::WorkW;
  localparam int AW = lcr_pkg::AddrW;
  localparam int CW = lcr_pkg::CoordW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CIRC, S_LINE, S_READ, S_RWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [lcr_pkg::CodeW-1:0] mem [lcr_pkg::Depth];
  logic [lcr_pkg::CodeW-1:0] rd_q;
  logic [AW:0]               clr_q;

  logic signed [W-1:0] cx_q, cy_q, x_q, y_q, d_q, ex_q, ey_q, dx_q, dy_q, m_q;
  logic signed [W-1:0] ux_q, uy_q;
  logic [2:0]          oct_q;
  logic [lcr_pkg::CodeW-1:0] code_q, pix_q;
  logic                xmaj_q, step_neg_q, rd_ok_q, last_q;

  logic signed [W-1:0] px, py;
  logic                pon, wr_en;
  logic [AW-1:0]       waddr;
  logic [lcr_pkg::CodeW-1:0] wdata;

  // one of the eight symmetric points per cycle
  always_comb begin
    px = cx_q; py = cy_q;
    unique case (oct_q)
      3'd0: begin px = cx_q + x_q; py = cy_q + y_q; end
      3'd1: begin px = cx_q + x_q; py = cy_q - y_q; end
      3'd2: begin px = cx_q - x_q; py = cy_q + y_q; end
      3'd3: begin px = cx_q - x_q; py = cy_q - y_q; end
      3'd4: begin px = cx_q + y_q; py = cy_q + x_q; end
      3'd5: begin px = cx_q - y_q; py = cy_q + x_q; end
      3'd6: begin px = cx_q + y_q; py = cy_q - x_q; end
      default: begin px = cx_q - y_q; py = cy_q - x_q; end
    endcase
    if (state_q == S_LINE) begin
      px = ux_q; py = uy_q;
    end
  end

  assign pon = px >= 0 && px < W'(lcr_pkg::GridSize) &&
               py >= 0 && py < W'(lcr_pkg::GridSize);

  always_comb begin
    wr_en = 1'b0;
    waddr = {px[CW-1:0], py[CW-1:0]};
    wdata = code_q;
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
      waddr = clr_q[AW-1:0];
      wdata = '0;
    end else if (state_q == S_CIRC) begin
      wr_en = pon;
    end else if (state_q == S_LINE) begin
      wr_en = pon && (xmaj_q ? (ux_q < ex_q) : (uy_q < ey_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    rd_q <= mem[{cx_q[CW-1:0], cy_q[CW-1:0]}];
  end

  assign cmd_take_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o  = (state_q == S_OUT);
  assign pixel_code_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pix_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(lcr_pkg::Depth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            cx_q   <= W'(cmd_i.ax);
            cy_q   <= W'(cmd_i.ay);
            pix_q  <= '0;
            oct_q  <= '0;
            x_q    <= '0;
            y_q    <= W'({1'b0, cmd_i.radius});
            d_q    <= W'(3) - (W'({1'b0, cmd_i.radius}) <<< 1);
            last_q <= 1'b0;
            code_q <= cmd_i.color;
            ux_q   <= W'(cmd_i.ax);
            uy_q   <= W'(cmd_i.ay);
            ex_q   <= W'(cmd_i.bx);
            ey_q   <= W'(cmd_i.by);
            begin
              logic signed [W-1:0] ddx, ddy, adx, ady;
              ddx = W'(cmd_i.bx) - W'(cmd_i.ax);
              ddy = W'(cmd_i.by) - W'(cmd_i.ay);
              adx = ddx < 0 ? -ddx : ddx;
              ady = ddy < 0 ? -ddy : ddy;
              dx_q <= adx;
              dy_q <= ady;
              xmaj_q <= adx > ady;
              step_neg_q <= (adx > ady) ? (ddy < 0) : (ddx < 0);
              m_q <= (adx > ady) ? (ady - adx) : (adx - ady);
            end
            unique case (cmd_i.op)
              lcr_pkg::OP_CIRCLE: state_q <= S_CIRC;
              lcr_pkg::OP_LINE: begin
                state_q <= S_LINE;
                code_q  <= lcr_pkg::LineCode;
              end
              lcr_pkg::OP_READ: state_q <= S_READ;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_CIRC: begin
          oct_q <= oct_q + 3'd1;
          if (oct_q == 3'd7) begin
            if (last_q) begin
              state_q <= S_OUT;
            end else begin
              last_q <= !(y_q >= x_q);
              if (!(y_q >= x_q)) state_q <= S_OUT;
              x_q <= x_q + W'(1);
              if (d_q > 0) begin
                y_q <= y_q - W'(1);
                d_q <= d_q + ((x_q + W'(1) - (y_q - W'(1))) <<< 2) + W'(10);
              end else begin
                d_q <= d_q + ((x_q + W'(1)) <<< 2) + W'(6);
              end
            end
          end
        end
        S_LINE: begin
          if (xmaj_q ? !(ux_q < ex_q) : !(uy_q < ey_q)) begin
            state_q <= S_OUT;
          end else if (xmaj_q) begin
            ux_q <= ux_q + W'(1);
            if (m_q >= 0) begin
              uy_q <= step_neg_q ? uy_q - W'(1) : uy_q + W'(1);
              m_q  <= m_q - dx_q + dy_q;
            end else m_q <= m_q + dy_q;
          end else begin
            uy_q <= uy_q + W'(1);
            if (m_q >= 0) begin
              ux_q <= step_neg_q ? ux_q - W'(1) : ux_q + W'(1);
              m_q  <= m_q - dy_q + dx_q;
            end else m_q <= m_q + dx_q;
          end
        end
        S_READ: begin
          rd_ok_q <= cx_q >= 0 && cx_q < W'(lcr_pkg::GridSize) &&
                     cy_q >= 0 && cy_q < W'(lcr_pkg::GridSize);
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          pix_q   <= rd_ok_q ? rd_q : '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> state_q == S_IDLE) else $error("take outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(pix_q))
    else $error("result dropped");
  a_clear_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !cmd_take_o && !out_valid_o) else $error("busy clear");
`endif

endmodule

>>> hw/rtl/line_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// line_circle_rasterizer
// draws circles and lines into a 256x256 frame of 4-bit codes, reads pixels
// ----------------------------------------------------------------------------
// After reset the frame is cleared one pixel per cycle before the first item
// runs. A circle plots each symmetric point of every midpoint step in turn;
// a line walks the pixels of its major extent; a read passes through its read
// and wait states. The single frame write port sets the pace.
// Items queue two deep in front, and each returns exactly one result item.
module line_circle_rasterizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic signed [lcr_pkg::InW-1:0] ax_i,
  input  logic signed [lcr_pkg::InW-1:0] ay_i,
  input  logic signed [lcr_pkg::InW-1:0] bx_i,
  input  logic signed [lcr_pkg::InW-1:0] by_i,
  input  logic [lcr_pkg::RadW-1:0]       radius_i,
  input  logic [lcr_pkg::CodeW-1:0]      color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lcr_pkg::CodeW-1:0]      pixel_code_o
);

  logic          cmd_valid, cmd_take;
  lcr_pkg::cmd_t cmd;

  lcr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .ax_i, .ay_i,
    .bx_i, .by_i, .radius_i, .color_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  lcr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .out_valid_o, .out_stall_i, .pixel_code_o
  );

endmodule

>>> tb/line_circle_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// line_circle_rasterizer_checker
// watches both channels of the rasterizer, keeps its own frame buffer and
// predicts every pixel code, comparing each result item with the oldest one
// ----------------------------------------------------------------------------
module line_circle_rasterizer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     op_i,
  input  logic signed [lcr_pkg::InW-1:0] ax_i,
  input  logic signed [lcr_pkg::InW-1:0] ay_i,
  input  logic signed [lcr_pkg::InW-1:0] bx_i,
  input  logic signed [lcr_pkg::InW-1:0] by_i,
  input  logic [lcr_pkg::RadW-1:0]       radius_i,
  input  logic [lcr_pkg::CodeW-1:0]      color_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [lcr_pkg::CodeW-1:0]      pixel_code_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             n_items_o,
  output int                             n_results_o
);

  logic [lcr_pkg::CodeW-1:0] frame [lcr_pkg::Depth];
  logic [lcr_pkg::CodeW-1:0] code_q [$];

  initial begin
    foreach (frame[k]) frame[k] = '0;
    fail_count_o = 0;
    n_items_o = 0;
    n_results_o = 0;
  end

  assign pending_o = code_q.size();

  task automatic report(input string what);
    fail_count_o++;
    $display("[%0t] error: %s", $time, what);
  endtask

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && x < lcr_pkg::GridSize && y >= 0 && y < lcr_pkg::GridSize;
  endfunction

  task automatic plot(input int x, input int y, input logic [lcr_pkg::CodeW-1:0] c);
    if (on_grid(x, y)) frame[x * lcr_pkg::GridSize + y] = c;
  endtask

  task automatic plot8(input int cx, input int cy, input int x, input int y,
                       input logic [lcr_pkg::CodeW-1:0] c);
    plot(cx + x, cy + y, c);
    plot(cx + x, cy - y, c);
    plot(cx - x, cy + y, c);
    plot(cx - x, cy - y, c);
    plot(cx + y, cy + x, c);
    plot(cx - y, cy + x, c);
    plot(cx + y, cy - x, c);
    plot(cx - y, cy - x, c);
  endtask

  task automatic draw_circle(input int cx, input int cy, input int r,
                             input logic [lcr_pkg::CodeW-1:0] c);
    int x;
    int y;
    int d;
    x = 0;
    y = r;
    d = 3 - 2 * r;
    plot8(cx, cy, x, y, c);
    while (y >= x) begin
      x++;
      if (d > 0) begin
        y--;
        d += 4 * (x - y) + 10;
      end else begin
        d += 4 * x + 6;
      end
      plot8(cx, cy, x, y, c);
    end
  endtask

  task automatic draw_line(input int x1, input int y1, input int x2, input int y2);
    int t;
    int dx;
    int dy;
    int dir;
    int m;
    int i;
    int j;
    dir = 1;
    if (x2 < x1) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    if (dy < 0) begin
      dir = -1;
      dy = -dy;
      // falling steep or exact diagonal: walk up y from the lower end
      if (dy >= dx) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
    end
    if (dx > dy) begin
      j = y1;
      m = dy - dx;
      for (i = x1; i < x2; i++) begin
        plot(i, j, lcr_pkg::LineCode);
        if (m >= 0) begin
          j += dir;
          m -= dx;
        end
        m += dy;
      end
    end else begin
      dy = y2 - y1;
      dx = x2 - x1;
      if (dx < 0) dx = -dx;
      i = x1;
      m = dx - dy;
      for (j = y1; j < y2; j++) begin
        plot(i, j, lcr_pkg::LineCode);
        if (m >= 0) begin
          i += dir;
          m -= dy;
        end
        m += dx;
      end
    end
  endtask

  always @(posedge clk_i) begin
    logic [lcr_pkg::CodeW-1:0] want;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      want = '0;
      case (lcr_pkg::op_e'(op_i))
        lcr_pkg::OP_CIRCLE: draw_circle(ax_i, ay_i, int'(radius_i), color_i);
        lcr_pkg::OP_LINE:   draw_line(ax_i, ay_i, bx_i, by_i);
        lcr_pkg::OP_READ:
          if (on_grid(ax_i, ay_i))
            want = frame[int'(ax_i) * lcr_pkg::GridSize + int'(ay_i)];
        default:   want = '0;
      endcase
      code_q.insert(code_q.size(), want);
      n_items_o++;
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      n_results_o++;
      if (code_q.size() == 0) begin
        report($sformatf("unexpected result item, pixel_code %0d", pixel_code_i));
      end else begin
        want = code_q.pop_front();
        if (pixel_code_i !== want)
          report($sformatf("pixel_code %0d, expected %0d", pixel_code_i, want));
      end
    end
  end

endmodule

>>> tb/line_circle_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// line_circle_rasterizer_tb
// drives directed and random circle, line, read and unknown-op items through the
// rasterizer under varying idle and stall patterns; the checker judges results
// ----------------------------------------------------------------------------
module line_circle_rasterizer_tb;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [1:0]                      op_i;
  logic signed [lcr_pkg::InW-1:0]  ax_i;
  logic signed [lcr_pkg::InW-1:0]  ay_i;
  logic signed [lcr_pkg::InW-1:0]  bx_i;
  logic signed [lcr_pkg::InW-1:0]  by_i;
  logic [lcr_pkg::RadW-1:0]        radius_i;
  logic [lcr_pkg::CodeW-1:0]       color_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [lcr_pkg::CodeW-1:0]       pixel_code_o;

  int fail_count;
  int pending;
  int n_items;
  int n_results;
  int idle_pct;
  int stall_pct;
  bit hold_req;

  line_circle_rasterizer u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .ax_i, .ay_i, .bx_i,
    .by_i, .radius_i, .color_i, .out_valid_o, .out_stall_i, .pixel_code_o
  );

  line_circle_rasterizer_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .ax_i, .ay_i,
    .bx_i, .by_i, .radius_i, .color_i, .out_valid_i(out_valid_o), .out_stall_i,
    .pixel_code_i(pixel_code_o), .fail_count_o(fail_count), .pending_o(pending),
    .n_items_o(n_items), .n_results_o(n_results)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("line_circle_rasterizer: mismatch");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int k = 0; k < 4000; k++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // call at a rising edge; returns at the edge that accepts the item, or after a random idle gap that follows it
  task automatic send(input lcr_pkg::op_e op, input int ax, input int ay, input int bx,
                      input int by, input int r, input int c);
    logic st;
    in_valid_i <= 1'b1;
    op_i       <= op;
    ax_i       <= ax[lcr_pkg::InW-1:0];
    ay_i       <= ay[lcr_pkg::InW-1:0];
    bx_i       <= bx[lcr_pkg::InW-1:0];
    by_i       <= by[lcr_pkg::InW-1:0];
    radius_i   <= r[lcr_pkg::RadW-1:0];
    color_i    <= c[lcr_pkg::CodeW-1:0];
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return $signed(13'($urandom));
    return int'($urandom_range(295)) - 20;
  endfunction

  task automatic send_random();
    int sel;
    int r;
    sel = $urandom_range(99);
    r = ($urandom_range(49) == 0) ? $urandom_range(4095) : $urandom_range(60);
    if (sel < 30)
      send(lcr_pkg::OP_CIRCLE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           r, $urandom_range(15));
    else if (sel < 55)
      send(lcr_pkg::OP_LINE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           $urandom_range(4095), $urandom_range(15));
    else if (sel < 95)
      send(lcr_pkg::OP_READ, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           $urandom_range(4095), $urandom_range(15));
    else
      send(lcr_pkg::OP_NONE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           $urandom_range(4095), $urandom_range(15));
  endtask

  initial begin
    int waited;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = lcr_pkg::OP_READ;
    ax_i       = '0;
    ay_i       = '0;
    bx_i       = '0;
    by_i       = '0;
    radius_i   = '0;
    color_i    = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items
    send(lcr_pkg::OP_READ, 5, 5, 0, 0, 0, 0);
    send(lcr_pkg::OP_CIRCLE, 128, 128, 0, 0, 0, 15);
    send(lcr_pkg::OP_READ, 128, 128, 0, 0, 0, 0);
    send(lcr_pkg::OP_CIRCLE, 100, 60, -4096, 4095, 20, 7);
    send(lcr_pkg::OP_READ, 100, 80, 0, 0, 0, 0);
    send(lcr_pkg::OP_CIRCLE, 0, 0, 0, 0, 4095, 5);
    send(lcr_pkg::OP_CIRCLE, -4096, 4095, 0, 0, 4095, 3);
    send(lcr_pkg::OP_LINE, 0, 0, 255, 255, 0, 0);
    send(lcr_pkg::OP_READ, 254, 254, 0, 0, 0, 0);
    send(lcr_pkg::OP_READ, 255, 255, 0, 0, 0, 0);
    send(lcr_pkg::OP_LINE, 10, 50, 50, 10, 0, 0);
    send(lcr_pkg::OP_READ, 40, 20, 0, 0, 0, 0);
    send(lcr_pkg::OP_LINE, 30, 30, 30, 30, 0, 0);
    send(lcr_pkg::OP_LINE, 60, 200, 70, 100, 0, 0);
    send(lcr_pkg::OP_LINE, 200, 5, 20, 9, 0, 0);
    send(lcr_pkg::OP_LINE, 4095, -4096, -4096, 4095, 0, 0);
    send(lcr_pkg::OP_READ, 127, 128, 0, 0, 0, 0);
    send(lcr_pkg::OP_READ, -1, 0, 0, 0, 0, 0);
    send(lcr_pkg::OP_READ, 256, 5, 0, 0, 0, 0);
    send(lcr_pkg::OP_READ, 4095, 4095, 0, 0, 0, 0);
    send(lcr_pkg::OP_READ, -4096, -4096, 0, 0, 0, 0);
    send(lcr_pkg::OP_NONE, 1, 2, 3, 4, 4095, 15);
    send(lcr_pkg::OP_READ, 0, 0, 0, 0, 0, 0);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 31) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 59 : 31) : 0;
      for (int k = 0; k < 300; k++) send_random();
    end

    // long receiver hold-off while items keep coming
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (int k = 0; k < 20; k++)
      send(lcr_pkg::OP_READ, $urandom_range(255), $urandom_range(255), 0, 0, 0, 0);
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 2_000_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);

    $display("covered %0d items and %0d results: circles, lines, reads, unknown op,",
             n_items, n_results);
    $display("off-grid clipping and reads, idle and stall phases, a long hold-off");
    if (fail_count == 0 && pending == 0)
      $display("line_circle_rasterizer: match");
    else
      $display("line_circle_rasterizer: mismatch");
    $finish;
  end

endmodule
